// ===== sv/scfp_pkg.sv =====
package scfp_pkg;

   localparam int CAPACITY = 32;
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int GROUP = 4;
   localparam logic [30:0] COUNT_MAX = 31'h7FFF_FFFF;
   localparam logic [7:0] BYTE_MAX = 8'd255;

   localparam logic [2:0] OPC_CLEAR = 3'd0;
   localparam logic [2:0] OPC_HIT = 3'd1;
   localparam logic [2:0] OPC_LOOKUP = 3'd2;
   localparam logic [2:0] OPC_FLATTEN = 3'd3;
   localparam logic [2:0] OPC_EMIT = 3'd4;

   localparam logic [1:0] KIND_ACK = 2'd0;
   localparam logic [1:0] KIND_REPLY = 2'd1;
   localparam logic [1:0] KIND_KEY = 2'd2;
   localparam logic [1:0] KIND_PACK = 2'd3;

   localparam logic [1:0] STAT_OK = 2'd0;
   localparam logic [1:0] STAT_FULL = 2'd1;
   localparam logic [1:0] STAT_MISS = 2'd2;

   typedef enum logic [2:0] {
      OP_CLEAR,
      OP_HIT,
      OP_LOOKUP,
      OP_FLATTEN,
      OP_EMIT,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] key;
      logic [15:0] amount;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [31:0] word;
      logic [30:0] value;
      logic        last;
   } res_type;

endpackage

// ===== sv/scfp_front.sv =====
module scfp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [2:0]         operation,
   input  logic [31:0]        key,
   input  logic [15:0]        amount,
   output logic               cmd_valid,
   output scfp_pkg::cmd_type  cmd,
   input  logic               cmd_take
);

   scfp_pkg::cmd_type slot_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   scfp_pkg::cmd_type decoded;
   logic do_wr, do_rd;

   always_comb begin
      case (operation)
         scfp_pkg::OPC_CLEAR: decoded.op = scfp_pkg::OP_CLEAR;
         scfp_pkg::OPC_HIT: decoded.op = scfp_pkg::OP_HIT;
         scfp_pkg::OPC_LOOKUP: decoded.op = scfp_pkg::OP_LOOKUP;
         scfp_pkg::OPC_FLATTEN: decoded.op = scfp_pkg::OP_FLATTEN;
         scfp_pkg::OPC_EMIT: decoded.op = scfp_pkg::OP_EMIT;
         default: decoded.op = scfp_pkg::OP_NONE;
      endcase
      decoded.key = key;
      decoded.amount = amount;
   end

   assign full = (fill_ff == 2'd2);
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd = slot_ff[rd_ptr_ff];
   assign do_wr = push && !full;
   assign do_rd = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_wr;
      rd_ptr_in = rd_ptr_ff ^ do_rd;
      fill_in = fill_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ===== sv/scfp_engine.sv =====
module scfp_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  scfp_pkg::cmd_type  cmd,
   output logic               cmd_take,
   output logic               res_valid,
   output scfp_pkg::res_type  res,
   input  logic               res_pop
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_REPLY,
      S_SEARCH,
      S_FLAT,
      S_FIND,
      S_KEY,
      S_PACK
   } state_type;

   localparam int CW = scfp_pkg::CNT_W;

   logic [31:0] keys_ff [scfp_pkg::CAPACITY];
   logic [30:0] counts_ff [scfp_pkg::CAPACITY];

   state_type state_ff, state_in;
   logic [CW-1:0] used_ff, used_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] changed_ff, changed_in;
   logic [CW-1:0] emitted_ff, emitted_in;
   scfp_pkg::cmd_type cmd_ff, cmd_in;
   scfp_pkg::res_type pend_ff, pend_in;
   scfp_pkg::res_type out_ff, out_in;
   logic out_valid_ff, out_valid_in;
   logic have_prev_ff, have_prev_in;
   logic [31:0] prev_ff, prev_in;
   logic best_ok_ff, best_ok_in;
   logic [31:0] best_key_ff, best_key_in;
   logic [30:0] best_cnt_ff, best_cnt_in;
   logic [1:0] gpos_ff, gpos_in;
   logic [31:0] packed_ff, packed_in;

   logic [scfp_pkg::IDX_W-1:0] rd_idx, wr_idx;
   logic [31:0] cur_key;
   logic [30:0] cur_cnt;
   logic [31:0] sum;
   logic [30:0] sum_sat;
   logic key_we, cnt_we;
   logic [30:0] wr_cnt;
   logic can_emit;
   logic [7:0] best_byte;

   assign rd_idx = idx_ff[scfp_pkg::IDX_W-1:0];
   assign cur_key = keys_ff[rd_idx];
   assign cur_cnt = counts_ff[rd_idx];
   assign sum = {1'b0, cur_cnt} + {16'd0, cmd_ff.amount};
   assign sum_sat = sum[31] ? scfp_pkg::COUNT_MAX : sum[30:0];
   assign can_emit = !out_valid_ff || res_pop;
   assign best_byte = (best_cnt_ff > 31'(scfp_pkg::BYTE_MAX)) ? scfp_pkg::BYTE_MAX
                                                              : best_cnt_ff[7:0];
   assign res_valid = out_valid_ff;
   assign res = out_ff;

   always_comb begin
      state_in = state_ff;
      used_in = used_ff;
      idx_in = idx_ff;
      changed_in = changed_ff;
      emitted_in = emitted_ff;
      cmd_in = cmd_ff;
      pend_in = pend_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff && !res_pop;
      have_prev_in = have_prev_ff;
      prev_in = prev_ff;
      best_ok_in = best_ok_ff;
      best_key_in = best_key_ff;
      best_cnt_in = best_cnt_ff;
      gpos_in = gpos_ff;
      packed_in = packed_ff;
      cmd_take = 1'b0;
      key_we = 1'b0;
      cnt_we = 1'b0;
      wr_idx = rd_idx;
      wr_cnt = sum_sat;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               cmd_in = cmd;
               idx_in = '0;
               changed_in = '0;
               emitted_in = '0;
               have_prev_in = 1'b0;
               best_ok_in = 1'b0;
               gpos_in = 2'd0;
               packed_in = '0;
               pend_in = '{kind: scfp_pkg::KIND_ACK, status: scfp_pkg::STAT_OK,
                           word: 32'd0, value: 31'd0, last: 1'b1};
               case (cmd.op)
                  scfp_pkg::OP_CLEAR: begin
                     used_in = '0;
                     state_in = S_REPLY;
                  end
                  scfp_pkg::OP_HIT, scfp_pkg::OP_LOOKUP: state_in = S_SEARCH;
                  scfp_pkg::OP_FLATTEN: state_in = S_FLAT;
                  scfp_pkg::OP_EMIT: state_in = (used_ff == '0) ? S_REPLY : S_FIND;
                  default: state_in = S_REPLY;
               endcase
            end
         end
         S_REPLY: begin
            if (can_emit) begin
               out_in = pend_ff;
               out_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SEARCH: begin
            if (idx_ff == used_ff) begin
               state_in = S_REPLY;
               if (cmd_ff.op == scfp_pkg::OP_HIT) begin
                  if (used_ff < CW'(scfp_pkg::CAPACITY)) begin
                     key_we = 1'b1;
                     cnt_we = 1'b1;
                     wr_idx = used_ff[scfp_pkg::IDX_W-1:0];
                     wr_cnt = {15'd0, cmd_ff.amount};
                     used_in = used_ff + 1'b1;
                  end else begin
                     pend_in.status = scfp_pkg::STAT_FULL;
                  end
               end else begin
                  pend_in.kind = scfp_pkg::KIND_REPLY;
                  pend_in.status = scfp_pkg::STAT_MISS;
               end
            end else if (cur_key == cmd_ff.key) begin
               state_in = S_REPLY;
               if (cmd_ff.op == scfp_pkg::OP_HIT) begin
                  cnt_we = 1'b1;
               end else begin
                  pend_in.kind = scfp_pkg::KIND_REPLY;
                  pend_in.value = cur_cnt;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_FLAT: begin
            if (idx_ff == used_ff) begin
               pend_in.kind = scfp_pkg::KIND_REPLY;
               pend_in.value = {{(31 - CW){1'b0}}, changed_ff};
               state_in = S_REPLY;
            end else begin
               if (cur_cnt > 31'd1) begin
                  cnt_we = 1'b1;
                  wr_cnt = 31'd1;
                  changed_in = changed_ff + 1'b1;
               end
               idx_in = idx_ff + 1'b1;
            end
         end
         S_FIND: begin
            if (idx_ff == used_ff) begin
               state_in = S_KEY;
            end else begin
               if ((!have_prev_ff || cur_key > prev_ff) &&
                   (!best_ok_ff || cur_key < best_key_ff)) begin
                  best_ok_in = 1'b1;
                  best_key_in = cur_key;
                  best_cnt_in = cur_cnt;
               end
               idx_in = idx_ff + 1'b1;
            end
         end
         S_KEY: begin
            if (can_emit) begin
               out_in = '{kind: scfp_pkg::KIND_KEY, status: scfp_pkg::STAT_OK,
                          word: best_key_ff, value: 31'd0, last: 1'b0};
               out_valid_in = 1'b1;
               packed_in[8*gpos_ff +: 8] = best_byte;
               emitted_in = emitted_ff + 1'b1;
               have_prev_in = 1'b1;
               prev_in = best_key_ff;
               best_ok_in = 1'b0;
               idx_in = '0;
               if (gpos_ff == 2'(scfp_pkg::GROUP - 1) || emitted_in == used_ff) begin
                  state_in = S_PACK;
               end else begin
                  gpos_in = gpos_ff + 1'b1;
                  state_in = S_FIND;
               end
            end
         end
         S_PACK: begin
            if (can_emit) begin
               out_in = '{kind: scfp_pkg::KIND_PACK, status: scfp_pkg::STAT_OK,
                          word: packed_ff, value: 31'd0, last: emitted_ff == used_ff};
               out_valid_in = 1'b1;
               gpos_in = 2'd0;
               packed_in = '0;
               state_in = (emitted_ff == used_ff) ? S_IDLE : S_FIND;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         out_valid_ff <= out_valid_in;
      end
      idx_ff <= idx_in;
      changed_ff <= changed_in;
      emitted_ff <= emitted_in;
      cmd_ff <= cmd_in;
      pend_ff <= pend_in;
      out_ff <= out_in;
      have_prev_ff <= have_prev_in;
      prev_ff <= prev_in;
      best_ok_ff <= best_ok_in;
      best_key_ff <= best_key_in;
      best_cnt_ff <= best_cnt_in;
      gpos_ff <= gpos_in;
      packed_ff <= packed_in;
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         keys_ff[wr_idx] <= cmd_ff.key;
      end
      if (cnt_we) begin
         counts_ff[wr_idx] <= wr_cnt;
      end
   end

`ifndef SYNTHESIS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(scfp_pkg::CAPACITY))
      else $error("Entry count exceeds the table capacity.");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !res_pop) |=> (out_valid_ff && $stable(out_ff)))
      else $error("A waiting result changed before its transfer.");
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIND || state_ff == S_KEY || state_ff == S_PACK) |->
      (emitted_ff <= used_ff && used_ff != '0))
      else $error("Emit walked past the stored entries.");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> (state_ff == S_IDLE && cmd_valid))
      else $error("A command was taken while the engine was busy.");
`endif

endmodule

// ===== sv/sparse_feature_count_packer_unit.sv =====
// Channel   Ports                                         Transfer when
// request   req_push req_full req_operation/key/amount    req_push && !req_full
// response  rsp_pop rsp_empty rsp_kind/status/word/...    rsp_pop && !rsp_empty
//
// Clear and undefined operations go from idle straight to the reply state in the engine.
// Hit and lookup scan the table one entry per cycle until the key is found or the stored entries end.
// Flatten scans the table once; emit rescans the table for each key,
// limited by the single table read port.
// Reset is synchronous and empties the table and both queues.
// Two requests queue ahead of the engine; either side may stall at any time.
module sparse_feature_count_packer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_operation,
   input  logic [31:0] req_key,
   input  logic [15:0] req_amount,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_kind,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_word,
   output logic [30:0] rsp_value,
   output logic        rsp_last
);

   logic cmd_valid, cmd_take, res_valid;
   scfp_pkg::cmd_type cmd;
   scfp_pkg::res_type res;

   scfp_front u_front (
      .clock(clock), .reset(reset), .push(req_push), .full(req_full),
      .operation(req_operation), .key(req_key), .amount(req_amount),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
   );

   scfp_engine u_engine (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd(cmd),
      .cmd_take(cmd_take), .res_valid(res_valid), .res(res), .res_pop(rsp_pop)
   );

   assign rsp_empty = !res_valid;
   assign rsp_kind = res.kind;
   assign rsp_status = res.status;
   assign rsp_word = res.word;
   assign rsp_value = res.value;
   assign rsp_last = res.last;

endmodule
